### rtl/sss_pkg.sv
// Shared types, constants and helpers for the smooth size search block.
// No dependencies; used by sss_div and smooth_size_search.
`timescale 1ns / 1ps

package sss_pkg;

	localparam int SIZE_WIDTH_DEF    = 32;
	localparam int PRIME_REG_WIDTH   = 16;
	localparam logic [15:0] MAX_PRIME_RESET = 16'd7;

	// Below this max prime the search builds products of small primes.
	localparam int SMALL_PRIME_LIMIT = 32;
	localparam int SMALL_PRIME_COUNT = 11;
	localparam int PRIME_WIDTH       = 5;
	localparam int LEVEL_WIDTH       = 4;

	// Trial divisor width (one above the max prime, so p + 1 fits).
	localparam int DIVISOR_WIDTH     = PRIME_REG_WIDTH + 1;

	localparam logic [1:0] PAR_ANY     = 2'd0;
	localparam logic [1:0] PAR_ODD     = 2'd1;
	localparam logic [1:0] PAR_EVEN    = 2'd2;
	localparam logic [1:0] PAR_ANY_ALT = 2'd3;

	localparam logic [PRIME_WIDTH-1:0] SMALL_PRIMES [SMALL_PRIME_COUNT] = '{
		5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29, 5'd31
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PS_NODE,
		ST_PS_POP,
		ST_PS_CONT,
		ST_SC_TEST,
		ST_SC_DIV,
		ST_SC_NEXT,
		ST_FLUSH
	} state_t;

	function automatic logic [PRIME_WIDTH-1:0] small_prime(input logic [LEVEL_WIDTH-1:0] idx);
		logic [PRIME_WIDTH-1:0] p;
		p = '0;
		if (32'(idx) < SMALL_PRIME_COUNT) begin
			p = SMALL_PRIMES[idx];
		end
		return p;
	endfunction

	// Number of small primes no larger than mp.
	function automatic logic [LEVEL_WIDTH-1:0] primes_upto(input logic [15:0] mp);
		logic [LEVEL_WIDTH-1:0] n;
		n = '0;
		for (int i = 0; i < SMALL_PRIME_COUNT; i++) begin
			if (16'(SMALL_PRIMES[i]) <= mp) begin
				n = n + 1'b1;
			end
		end
		return n;
	endfunction

endpackage

### rtl/sss_div.sv
// Restoring divider, one quotient bit per cycle, shared by the trial division.
// Depends on sss_pkg for the divisor width.
`timescale 1ns / 1ps

module sss_div #(
	parameter int SIZE_WIDTH = sss_pkg::SIZE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [SIZE_WIDTH-1:0]                dividend,
	input  logic [sss_pkg::PRIME_REG_WIDTH-1:0]  divisor,
	output logic                                 done,
	output logic [SIZE_WIDTH-1:0]                quotient,
	output logic [sss_pkg::PRIME_REG_WIDTH-1:0]  remainder
);

	localparam int RW   = sss_pkg::PRIME_REG_WIDTH;
	localparam int CNTW = $clog2(SIZE_WIDTH + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] count_q;
	logic [SIZE_WIDTH-1:0] work_q;
	logic [RW-1:0]   rem_q;
	logic [RW-1:0]   den_q;

	logic [RW:0]     trial;
	logic            fits;
	logic [RW:0]     diff;

	assign trial = {rem_q, work_q[SIZE_WIDTH-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q && (count_q == CNTW'(1));
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNTW'(SIZE_WIDTH);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[RW-1:0] : trial[RW-1:0];
			work_q <= {work_q[SIZE_WIDTH-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

### rtl/smooth_size_search.sv
// Smooth size search: smallest size >= start, of the asked parity, whose prime factors are <= max_prime.
// A start of 2 or less is passed straight through; otherwise, below a max prime of 32,
// a depth-first product search builds the size from small primes, else a scan tests
// candidates by trial division. One item at a time; the divider sets the scan pace.
// Asynchronous active-low reset: idle, no result held, max_prime back to 7. Uses sss_pkg, sss_div.
`timescale 1ns / 1ps

module smooth_size_search #(
	parameter int SIZE_WIDTH = sss_pkg::SIZE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [31:0] start_size,
	input  logic [1:0]  parity_mode,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [31:0] smooth_size,
	output logic        not_found,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	localparam int SW    = SIZE_WIDTH;
	localparam int PW    = sss_pkg::PRIME_WIDTH;
	localparam int LW    = sss_pkg::LEVEL_WIDTH;
	localparam int RW    = sss_pkg::PRIME_REG_WIDTH;
	localparam int DW    = sss_pkg::DIVISOR_WIDTH;
	localparam int PRODW = SW + PW;
	localparam int SQW   = 2 * DW;
	localparam int CMPW  = (SW > SQW) ? SW : SQW;
	localparam int DEPTH = sss_pkg::SMALL_PRIME_COUNT;

	sss_pkg::state_t state_q, state_d;

	// Configuration
	logic [RW-1:0] max_prime_q;

	// Item context and result
	logic [1:0]    mode_q;
	logic [SW-1:0] res_q;
	logic          nf_q;

	// Output register
	logic          out_valid_q;
	logic [31:0]   out_size_q;
	logic          out_nf_q;

	// Product search: depth-first walk over products of the selected primes.
	// The stack holds one pending product per level; level equals prime index, less one in odd mode.
	logic [LW-1:0] j_q;
	logic [LW-1:0] cnt_q;
	logic          off_q;
	logic [SW-1:0] cur_q;
	logic [SW-1:0] goal_q;
	logic [SW-1:0] bound_q;
	logic [SW-1:0] best_q;
	logic          have_best_q;
	logic [SW-1:0] stk_q [DEPTH];

	// Candidate scan by trial division
	logic [SW-1:0]  c_q;
	logic [SW-1:0]  v_q;
	logic [DW-1:0]  d_q;
	logic [SQW-1:0] dsq_q;   // always d_q squared, kept incrementally
	logic           step_q;  // 1: step of two (parity asked)

	// Input decode
	logic          accept;
	logic [SW+31:0] n_ext;
	logic [SW-1:0] n_in;
	logic [SW-1:0] limit;
	logic [1:0]    mode_in;
	logic          small_in;
	logic          ps_sel;
	logic [LW-1:0] pcount;
	logic          off_in;
	logic [LW-1:0] cnt_in;
	logic          mismatch;
	logic          n_is_max;

	// Product search decode
	logic            cur_ge_goal;
	logic            cur_better;
	logic            j_end;
	logic [PW-1:0]   prime_cur;
	logic [PRODW-1:0] prod;
	logic            prod_over;
	logic            prod_ge_best;
	logic [LW-1:0]   rd_idx;
	logic [SW-1:0]   stk_rd;
	logic [SW-1:0]   ps_res;

	// Scan decode
	logic          d_ok;
	logic          sq_ok;
	logic          v_smooth;
	logic [SW:0]   c_next;
	logic          c_wrap;

	// Divider
	logic          div_start;
	logic [SW-1:0] div_dividend;
	logic          div_done;
	logic [SW-1:0] div_quo;
	logic [RW-1:0] div_rem;
	logic          div_exact;

	logic [SW+31:0] res_ext;

	// ---------------------------------------------------------------
	// Input decode: start is taken to SIZE_WIDTH bits, code 3 means any parity.
	assign accept   = req_valid && req_ready;
	assign n_ext    = {{SW{1'b0}}, start_size};
	assign n_in     = n_ext[SW-1:0];
	assign limit    = '1;
	assign mode_in  = (parity_mode == sss_pkg::PAR_ANY_ALT) ? sss_pkg::PAR_ANY : parity_mode;
	assign small_in = n_in <= SW'(2);
	assign ps_sel   = max_prime_q < RW'(sss_pkg::SMALL_PRIME_LIMIT);
	assign pcount   = sss_pkg::primes_upto(max_prime_q);
	// Odd results leave out the prime two, which is always first in the table.
	assign off_in   = mode_in == sss_pkg::PAR_ODD;
	assign cnt_in   = pcount - LW'(off_in && (pcount != '0));
	assign mismatch = ((mode_in == sss_pkg::PAR_ODD) && !n_in[0]) ||
	                  ((mode_in == sss_pkg::PAR_EVEN) && n_in[0]);
	assign n_is_max = n_in == limit;

	// ---------------------------------------------------------------
	// Product search. In even mode it looks for half the size and doubles at
	// the end, with goal ceil(n/2) and bound limit/2.
	assign cur_ge_goal  = cur_q >= goal_q;
	assign cur_better   = !have_best_q || (cur_q < best_q);
	assign j_end        = j_q >= cnt_q;
	assign prime_cur    = sss_pkg::small_prime(j_q + LW'(off_q));
	assign prod         = PRODW'(cur_q) * PRODW'(prime_cur);
	assign prod_over    = prod > PRODW'(bound_q);
	assign prod_ge_best = have_best_q && (prod >= PRODW'(best_q));
	assign rd_idx       = (j_q == '0) ? '0 : j_q - 1'b1;
	assign stk_rd       = stk_q[rd_idx];
	assign ps_res       = (mode_q == sss_pkg::PAR_EVEN) ? {best_q[SW-2:0], 1'b0} : best_q;

	// ---------------------------------------------------------------
	// Trial division of one candidate: divide out d while it divides, then
	// d + 1, until d passes max_prime or d squared passes what is left.
	assign d_ok     = d_q <= DW'(max_prime_q);
	assign sq_ok    = CMPW'(dsq_q) <= CMPW'(v_q);
	assign v_smooth = (v_q == SW'(1)) || (CMPW'(v_q) <= CMPW'(max_prime_q));
	assign c_next   = {1'b0, c_q} + (SW + 1)'({step_q, !step_q});
	assign c_wrap   = c_next[SW];

	assign div_exact    = div_rem == '0;
	// Back-to-back divisions by the same d take the fresh quotient directly.
	assign div_dividend = (state_q == sss_pkg::ST_SC_DIV) ? div_quo : v_q;

	sss_div #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (d_q[RW-1:0]),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// ---------------------------------------------------------------
	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		case (state_q)
			sss_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (accept) begin
					if (small_in) begin
						state_d = sss_pkg::ST_FLUSH;
					end else if (ps_sel) begin
						state_d = sss_pkg::ST_PS_NODE;
					end else if (mismatch && n_is_max) begin
						state_d = sss_pkg::ST_FLUSH;
					end else begin
						state_d = sss_pkg::ST_SC_TEST;
					end
				end
			end
			sss_pkg::ST_PS_NODE: begin
				if (cur_ge_goal || j_end) begin
					state_d = sss_pkg::ST_PS_POP;
				end
			end
			sss_pkg::ST_PS_POP: begin
				if (j_q == '0) begin
					state_d = sss_pkg::ST_FLUSH;
				end else begin
					state_d = sss_pkg::ST_PS_CONT;
				end
			end
			sss_pkg::ST_PS_CONT: begin
				if (prod_over || prod_ge_best) begin
					state_d = sss_pkg::ST_PS_POP;
				end else begin
					state_d = sss_pkg::ST_PS_NODE;
				end
			end
			sss_pkg::ST_SC_TEST: begin
				if (d_ok && sq_ok) begin
					div_start = 1'b1;
					state_d   = sss_pkg::ST_SC_DIV;
				end else if (v_smooth) begin
					state_d = sss_pkg::ST_FLUSH;
				end else begin
					state_d = sss_pkg::ST_SC_NEXT;
				end
			end
			sss_pkg::ST_SC_DIV: begin
				if (div_done) begin
					if (div_exact) begin
						div_start = 1'b1;
					end else begin
						state_d = sss_pkg::ST_SC_TEST;
					end
				end
			end
			sss_pkg::ST_SC_NEXT: begin
				if (c_wrap) begin
					state_d = sss_pkg::ST_FLUSH;
				end else begin
					state_d = sss_pkg::ST_SC_TEST;
				end
			end
			sss_pkg::ST_FLUSH: begin
				if (!out_valid_q || rsp_ready) begin
					state_d = sss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sss_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_prime_q <= sss_pkg::MAX_PRIME_RESET;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_prime_q <= cfg_wr_data;
			end
			if (accept) begin
				have_best_q <= 1'b0;
			end else if (state_q == sss_pkg::ST_PS_NODE && cur_ge_goal && cur_better) begin
				have_best_q <= 1'b1;
			end
			if (state_q == sss_pkg::ST_FLUSH && (!out_valid_q || rsp_ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sss_pkg::ST_IDLE: begin
				if (accept) begin
					mode_q  <= mode_in;
					res_q   <= n_in;
					nf_q    <= !small_in && !ps_sel && mismatch && n_is_max;
					j_q     <= '0;
					cnt_q   <= cnt_in;
					off_q   <= off_in;
					cur_q   <= SW'(1);
					if (mode_in == sss_pkg::PAR_EVEN) begin
						goal_q  <= (n_in >> 1) + SW'(n_in[0]);
						bound_q <= limit >> 1;
					end else begin
						goal_q  <= n_in;
						bound_q <= limit;
					end
					c_q    <= n_in + SW'(mismatch);
					v_q    <= n_in + SW'(mismatch);
					d_q    <= DW'(2);
					dsq_q  <= SQW'(4);
					step_q <= mode_in != sss_pkg::PAR_ANY;
				end
			end
			sss_pkg::ST_PS_NODE: begin
				if (cur_ge_goal) begin
					if (cur_better) begin
						best_q <= cur_q;
					end
				end else if (!j_end) begin
					stk_q[j_q] <= cur_q;
					j_q        <= j_q + 1'b1;
				end
			end
			sss_pkg::ST_PS_POP: begin
				if (j_q == '0) begin
					if (have_best_q) begin
						res_q <= ps_res;
					end else begin
						nf_q <= 1'b1;
					end
				end else begin
					j_q   <= j_q - 1'b1;
					cur_q <= stk_rd;
				end
			end
			sss_pkg::ST_PS_CONT: begin
				if (!(prod_over || prod_ge_best)) begin
					cur_q <= prod[SW-1:0];
				end
			end
			sss_pkg::ST_SC_TEST: begin
				if (!(d_ok && sq_ok) && v_smooth) begin
					res_q <= c_q;
				end
			end
			sss_pkg::ST_SC_DIV: begin
				if (div_done) begin
					if (div_exact) begin
						v_q <= div_quo;
					end else begin
						d_q   <= d_q + 1'b1;
						dsq_q <= dsq_q + SQW'({d_q, 1'b1});
					end
				end
			end
			sss_pkg::ST_SC_NEXT: begin
				if (c_wrap) begin
					nf_q <= 1'b1;
				end else begin
					c_q   <= c_next[SW-1:0];
					v_q   <= c_next[SW-1:0];
					d_q   <= DW'(2);
					dsq_q <= SQW'(4);
				end
			end
			sss_pkg::ST_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	// Output register: the result field is 32 bits whatever SIZE_WIDTH is.
	assign res_ext = {32'b0, res_q};

	always_ff @(posedge clk) begin
		if (state_q == sss_pkg::ST_FLUSH && (!out_valid_q || rsp_ready)) begin
			out_size_q <= res_ext[31:0];
			out_nf_q   <= nf_q;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign smooth_size = out_size_q;
	assign not_found   = out_nf_q;

	// ---------------------------------------------------------------
	// Checks
	a_small_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && small_in |=> state_q == sss_pkg::ST_FLUSH && res_q == $past(n_in) && !nf_q)
		else $error("small start not passed straight through");

	a_best_meets_goal: assert property (@(posedge clk) disable iff (!arst_n)
		have_best_q |-> best_q >= goal_q)
		else $error("best product below goal");

	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sss_pkg::ST_SC_TEST || state_q == sss_pkg::ST_SC_DIV)
		|-> dsq_q == SQW'(d_q) * SQW'(d_q))
		else $error("divisor square out of step with divisor");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == sss_pkg::ST_SC_DIV)
		else $error("divider finished outside trial division");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sss_pkg::ST_PS_NODE |-> j_q <= cnt_q)
		else $error("search level beyond selected primes");

endmodule

### tb/smooth_size_search_tb.sv
// Testbench for smooth_size_search: valid/ready driver and monitor fed from a queue of items,
// with a built-in predictor of the next smooth size checked field by field.
// Depends on sss_pkg (parity codes, reset value, small prime limit) and the RTL top level.
`timescale 1ns / 1ps

module smooth_size_search_tb;

	localparam int     CLK_HALF      = 2;
	localparam int     RESET_CYCLES  = 8;
	// Idle cycles before a register write or the verdict, to cover any tail.
	localparam int     SETTLE_CYCLES = 8;
	// Total cycles allowed before calling it a hang.
	localparam longint CYCLE_LIMIT   = 25_000_000;
	localparam int     ITEMS_PER_SET = 19;

	localparam longint unsigned SIZE_MASK = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] start;
		logic [1:0]  mode;
	} size_req_t;

	typedef struct packed {
		logic [31:0] size;
		logic        miss;
	} size_rsp_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        req_valid   = 1'b0;
	logic        req_ready;
	logic [31:0] start_size  = '0;
	logic [1:0]  parity_mode = sss_pkg::PAR_ANY;
	logic        rsp_valid;
	logic        rsp_ready   = 1'b0;
	logic [31:0] smooth_size;
	logic        not_found;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	size_req_t   pending_reqs[$];   // items waiting for the driver
	size_rsp_t   awaited_sizes[$];  // predicted results, oldest first
	logic [15:0] prime_cap = sss_pkg::MAX_PRIME_RESET;  // shadow of max_prime
	int          issued     = 0;
	int          accepted   = 0;
	int          errors     = 0;
	longint      cycles     = 0;
	bit          calm       = 1'b0;  // no idling on either side while set
	int          send_gap   = 0;
	int          stall_left = 0;

	smooth_size_search dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.start_size  (start_size),
		.parity_mode (parity_mode),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.smooth_size (smooth_size),
		.not_found   (not_found),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Trial division by rising divisors up to the cap or sqrt(v), whichever
	// comes first; what is left must be 1 or itself no larger than the cap.
	function automatic bit trial_smooth(longint unsigned v, longint unsigned cap);
		longint unsigned d;
		d = 2;
		while (d <= cap && d * d <= v) begin
			while (v % d == 0)
				v = v / d;
			d++;
		end
		return (v == 1) || (v <= cap);
	endfunction

	// Least product of the allowed small primes lying in [lo, hi]; 0 if none.
	// Depth-first over (prime index, product) with an explicit stack; a branch
	// is dropped once it cannot beat the best product found so far.
	function automatic longint unsigned least_product(longint unsigned lo, longint unsigned hi,
			logic [15:0] cap, bit skip_two);
		longint unsigned primes[16];
		int              stk_lvl[128];
		longint unsigned stk_prod[128];
		int              n_primes, sp, lvl;
		longint unsigned best, cur, nxt, p, q;
		bit              is_p;
		n_primes = 0;
		for (p = 2; p < sss_pkg::SMALL_PRIME_LIMIT && p <= cap; p++) begin
			is_p = 1'b1;
			for (q = 2; q < p; q++)
				if (p % q == 0)
					is_p = 1'b0;
			if (is_p && !(skip_two && p == 2)) begin
				primes[n_primes] = p;
				n_primes++;
			end
		end
		best = 0;
		stk_lvl[0]  = 0;
		stk_prod[0] = 1;
		sp = 1;
		while (sp > 0) begin
			sp--;
			lvl = stk_lvl[sp];
			cur = stk_prod[sp];
			if (best == 0 || cur < best) begin
				if (cur >= lo) begin
					best = cur;
				end else if (lvl < n_primes) begin
					// leave this prime out ...
					stk_lvl[sp]  = lvl + 1;
					stk_prod[sp] = cur;
					sp++;
					// ... or take it once more, staying on the same prime
					p   = primes[lvl];
					nxt = cur * p;
					if (cur <= hi / p && (best == 0 || nxt < best)) begin
						stk_lvl[sp]  = lvl;
						stk_prod[sp] = nxt;
						sp++;
					end
				end
			end
		end
		return best;
	endfunction

	function automatic size_rsp_t predict_size(size_req_t rq, logic [15:0] cap);
		size_rsp_t       r;
		longint unsigned n, c, step, found_v, best;
		logic [1:0]      mode;
		bit              hit, searching;
		n       = rq.start;
		mode    = (rq.mode == sss_pkg::PAR_ANY_ALT) ? sss_pkg::PAR_ANY : rq.mode;
		hit     = 1'b1;
		found_v = n;
		if (n > 2) begin
			if (cap < sss_pkg::SMALL_PRIME_LIMIT) begin
				// build the size from small primes; even sizes are twice a product
				if (mode == sss_pkg::PAR_EVEN) begin
					best    = least_product(n / 2 + (n & 1), SIZE_MASK / 2, cap, 1'b0);
					found_v = best * 2;
				end else begin
					best    = least_product(n, SIZE_MASK, cap, mode == sss_pkg::PAR_ODD);
					found_v = best;
				end
				hit = (best != 0);
			end else begin
				// candidate scan, stepping by two once the parity is right
				step = (mode == sss_pkg::PAR_ANY) ? 1 : 2;
				c    = n;
				if ((mode == sss_pkg::PAR_ODD && (c & 1) == 0) ||
						(mode == sss_pkg::PAR_EVEN && (c & 1) != 0)) begin
					if (c == SIZE_MASK)
						hit = 1'b0;
					else
						c++;
				end
				searching = hit;
				while (searching) begin
					if (trial_smooth(c, cap)) begin
						found_v   = c;
						searching = 1'b0;
					end else if (c > SIZE_MASK - step) begin
						hit       = 1'b0;
						searching = 1'b0;
					end else begin
						c += step;
					end
				end
			end
			if (!hit)
				found_v = n;
		end
		r.size = found_v[31:0];
		r.miss = !hit;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// Widest start worth sending for a given cap: the search cost grows with the
	// count of smooth numbers below the start (product search) or with the
	// trial divisions per candidate (scan), so larger caps get smaller starts.
	function automatic int start_bits(logic [15:0] cap);
		if (cap <= 7)
			return 32;
		if (cap <= 13)
			return 24;
		if (cap < sss_pkg::SMALL_PRIME_LIMIT)
			return 16;
		return 12;
	endfunction

	task automatic queue_req(logic [31:0] s, logic [1:0] m);
		size_req_t rq;
		rq.start = s;
		rq.mode  = m;
		pending_reqs.push_back(rq);
	endtask

	// Random start, log-uniform in size (top bit of the chosen width set),
	// with the small-start shortcut hit now and then.
	task automatic queue_random(int bits);
		logic [31:0] s;
		int          w;
		if ($urandom_range(0, 19) == 0) begin
			s = $urandom_range(0, 2);
		end else begin
			w = $urandom_range(2, bits);
			s = $urandom;
			if (w < 32)
				s = s & ((32'd1 << w) - 1);
			s[w-1] = 1'b1;
		end
		queue_req(s, 2'($urandom_range(0, 3)));
	endtask

	// Block idle: nothing queued, nothing on the bus, no result outstanding.
	task automatic drain();
		while (pending_reqs.size() != 0 || issued != accepted || awaited_sizes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_prime_cap(logic [15:0] v);
		@(negedge clk);
		cfg_wr_data <= v;
		cfg_wr_en   <= 1'b1;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		prime_cap    = v;
	endtask

	// One random set under a fresh cap. The sender holds off halfway until
	// every result of the first half is back.
	task automatic random_set(logic [15:0] cap);
		int i;
		write_prime_cap(cap);
		calm = ($urandom_range(0, 3) == 0);
		for (i = 0; i < ITEMS_PER_SET / 2; i++)
			queue_random(start_bits(cap));
		drain();
		for (i = ITEMS_PER_SET / 2; i < ITEMS_PER_SET; i++)
			queue_random(start_bits(cap));
		drain();
	endtask

	// ------------------------------------------------------------------
	// Request driver: changes on the falling edge, holds until accepted
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		size_req_t head_req;
		if (arst_n) begin
			if (issued != accepted) begin
				// item still on the bus; keep valid and payload as they are
			end else if (send_gap > 0) begin
				req_valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (pending_reqs.size() != 0) begin
				head_req     = pending_reqs.pop_front();
				start_size  <= head_req.start;
				parity_mode <= head_req.mode;
				req_valid   <= 1'b1;
				issued++;
				send_gap    <= pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready <= 1'b1;
			if ($urandom_range(0, 2) == 0)
				stall_left <= pick_gap();
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on each accepted item, checks each accepted result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		size_req_t taken;
		size_rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				taken.start = start_size;
				taken.mode  = parity_mode;
				awaited_sizes.push_back(predict_size(taken, prime_cap));
				accepted++;
			end
			if (rsp_valid && rsp_ready) begin
				if (awaited_sizes.size() == 0) begin
					errors++;
					$display("%0t: result with none pending: smooth_size %0d not_found %0b",
						$time, smooth_size, not_found);
				end else begin
					want = awaited_sizes.pop_front();
					if (smooth_size !== want.size) begin
						errors++;
						$display("%0t: smooth_size expected %0d got %0d",
							$time, want.size, smooth_size);
					end
					if (not_found !== want.miss) begin
						errors++;
						$display("%0t: not_found expected %0b got %0b",
							$time, want.miss, not_found);
					end
				end
			end
		end
	end

	// Hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, awaited_sizes.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset cap of 7: small-start shortcut in every parity code, a small
		// search per parity, and the top of the range with no 7-smooth size left.
		queue_req(32'd0, sss_pkg::PAR_ANY);
		queue_req(32'd1, sss_pkg::PAR_ODD);
		queue_req(32'd2, sss_pkg::PAR_EVEN);
		queue_req(32'd2, sss_pkg::PAR_ANY_ALT);
		queue_req(32'd3, sss_pkg::PAR_ANY);
		queue_req(32'd11, sss_pkg::PAR_ODD);
		queue_req(32'd11, sss_pkg::PAR_EVEN);
		queue_req(32'd11, sss_pkg::PAR_ANY_ALT);
		queue_req(32'hFFFF_FFFF, sss_pkg::PAR_ANY);
		queue_req(32'hFFFF_FFFF, sss_pkg::PAR_ODD);
		queue_req(32'hFFFF_FFFF, sss_pkg::PAR_EVEN);
		drain();

		// Cap 2: odd request cannot be met; powers of two up to the top bit.
		write_prime_cap(16'd2);
		queue_req(32'd5, sss_pkg::PAR_ODD);
		queue_req(32'd5, sss_pkg::PAR_EVEN);
		queue_req(32'h7FFF_FFFF, sss_pkg::PAR_ANY);
		queue_req(32'h8000_0001, sss_pkg::PAR_ANY);
		drain();

		// Cap below two: nothing above 2 qualifies.
		write_prime_cap(16'd0);
		queue_req(32'd3, sss_pkg::PAR_ANY);
		queue_req(32'hFFFF_FFFF, sss_pkg::PAR_ANY_ALT);
		drain();

		// Largest cap, scan path: all-ones start runs off the end in each parity.
		write_prime_cap(16'hFFFF);
		queue_req(32'hFFFF_FFFF, sss_pkg::PAR_ANY);
		queue_req(32'hFFFF_FFFF, sss_pkg::PAR_ODD);
		queue_req(32'hFFFF_FFFF, sss_pkg::PAR_EVEN);
		queue_req(32'd4095, sss_pkg::PAR_ODD);
		queue_req(32'd60000, sss_pkg::PAR_ANY_ALT);
		drain();

		// Random sets across both search paths and the cap extremes.
		random_set(16'd5);
		random_set(16'd31);
		random_set(16'd1);
		random_set(16'd37);
		random_set(16'd13);
		random_set(16'd3);
		random_set(16'd1000);
		random_set(16'd29);
		random_set(16'hFFFF);
		random_set(16'd17);
		random_set(16'd2);
		random_set(16'd7);
		random_set(16'd32);
		random_set(16'd11);
		random_set(16'd0);

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### files.f
rtl/sss_pkg.sv
rtl/sss_div.sv
rtl/smooth_size_search.sv
tb/smooth_size_search_tb.sv
